// ===== rtl/xtu_pkg.sv =====
// ----------------------------------------------------------------------------
// xtu_pkg
// Shared types, codes and entity tables of the UTF-8 check and XML escape block.
// ----------------------------------------------------------------------------
package xtu_pkg;

  // Error codes reported on the last output byte of a run
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_LEAD  = 3'd1;
  localparam logic [2:0] ERR_TRUNC     = 3'd2;
  localparam logic [2:0] ERR_BAD_CONT  = 3'd3;
  localparam logic [2:0] ERR_NONCANON  = 3'd4;
  localparam logic [2:0] ERR_FORBIDDEN = 3'd5;

  // Descriptor queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    K_PLAIN = 3'd0,
    K_AMP   = 3'd1,
    K_LT    = 3'd2,
    K_GT    = 3'd3,
    K_QUOT  = 3'd4,
    K_TAB   = 3'd5,
    K_LF    = 3'd6,
    K_CR    = 3'd7
  } kind_e;

  // One classified input byte
  typedef struct packed {
    logic [7:0] data_byte;
    kind_e      kind;
    logic       eos;
    logic [2:0] report;
    logic       err_seen;
  } desc_t;

  function automatic logic xml_char_ok(input logic [20:0] cp);
    return (cp == 21'h09) || (cp == 21'h0A) || (cp == 21'h0D) ||
           (cp >= 21'h20 && cp <= 21'hD7FF) ||
           (cp >= 21'hE000 && cp <= 21'hFFFD) ||
           (cp >= 21'h10000 && cp <= 21'h10FFFF);
  endfunction

  function automatic logic [2:0] ent_len(input kind_e k);
    logic [2:0] n;
    case (k)
      K_PLAIN: n = 3'd1;
      K_AMP:   n = 3'd5;
      K_LT:    n = 3'd4;
      K_GT:    n = 3'd4;
      K_QUOT:  n = 3'd6;
      default: n = 3'd5;
    endcase
    return n;
  endfunction

  // Byte idx of the entity for kind k; a plain byte passes through
  function automatic logic [7:0] ent_byte(input kind_e k, input logic [2:0] idx,
                                          input logic [7:0] raw);
    logic [7:0] b;
    b = 8'h3B;
    if (idx == 3'd0) begin
      b = (k == K_PLAIN) ? raw : 8'h26;
    end else begin
      case (k)
        K_AMP: begin
          case (idx)
            3'd1:    b = 8'h61;
            3'd2:    b = 8'h6D;
            3'd3:    b = 8'h70;
            default: b = 8'h3B;
          endcase
        end
        K_LT: begin
          case (idx)
            3'd1:    b = 8'h6C;
            3'd2:    b = 8'h74;
            default: b = 8'h3B;
          endcase
        end
        K_GT: begin
          case (idx)
            3'd1:    b = 8'h67;
            3'd2:    b = 8'h74;
            default: b = 8'h3B;
          endcase
        end
        K_QUOT: begin
          case (idx)
            3'd1:    b = 8'h71;
            3'd2:    b = 8'h75;
            3'd3:    b = 8'h6F;
            3'd4:    b = 8'h74;
            default: b = 8'h3B;
          endcase
        end
        K_TAB, K_LF, K_CR: begin
          case (idx)
            3'd1:    b = 8'h23;
            3'd2:    b = 8'h78;
            3'd3:    b = (k == K_TAB) ? 8'h39 : ((k == K_LF) ? 8'h41 : 8'h44);
            default: b = 8'h3B;
          endcase
        end
        default: b = 8'h3B;
      endcase
    end
    return b;
  endfunction

endpackage

// ===== rtl/xtu_front.sv =====
// ----------------------------------------------------------------------------
// xtu_front
// UTF-8 decode, XML character check and escape classification per byte.
// ----------------------------------------------------------------------------
module xtu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          mode_i,
  input  logic          eos_i,
  input  logic          full_i,
  output logic          push_o,
  output xtu_pkg::desc_t desc_o
);
  import xtu_pkg::*;

  logic [20:0] acc_q, acc_d;
  logic [1:0]  rem_q, rem_d;
  logic [1:0]  len_q, len_d;
  logic        sticky_q, sticky_d;
  logic [20:0] cp;
  logic [2:0]  err;
  kind_e       kind;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;
  assign cp      = {acc_q[14:0], data_byte_i[5:0]};

  always_comb begin
    err   = ERR_NONE;
    acc_d = acc_q;
    rem_d = rem_q;
    len_d = len_q;
    if (rem_q == 2'd0) begin
      if (!data_byte_i[7]) begin
        if (!xml_char_ok({13'd0, data_byte_i})) err = ERR_FORBIDDEN;
      end else if (data_byte_i inside {[8'hC2:8'hDF]}) begin
        acc_d = {16'd0, data_byte_i[4:0]};
        rem_d = 2'd1;
        len_d = 2'd1;
      end else if (data_byte_i inside {[8'hE0:8'hEF]}) begin
        acc_d = {17'd0, data_byte_i[3:0]};
        rem_d = 2'd2;
        len_d = 2'd2;
      end else if (data_byte_i inside {[8'hF0:8'hF4]}) begin
        acc_d = {18'd0, data_byte_i[2:0]};
        rem_d = 2'd3;
        len_d = 2'd3;
      end else begin
        err = ERR_BAD_LEAD;
      end
    end else if (data_byte_i[7:6] != 2'b10) begin
      err   = ERR_BAD_CONT;
      acc_d = '0;
      rem_d = 2'd0;
      len_d = 2'd0;
    end else begin
      acc_d = cp;
      rem_d = rem_q - 2'd1;
      if (rem_q == 2'd1) begin
        if ((len_q == 2'd2 && cp < 21'h800) || (len_q == 2'd3 && cp < 21'h10000) ||
            cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
          err = ERR_NONCANON;
        end else if (!xml_char_ok(cp)) begin
          err = ERR_FORBIDDEN;
        end
        len_d = 2'd0;
      end
    end
    if (eos_i && rem_d != 2'd0 && err == ERR_NONE) err = ERR_TRUNC;
    sticky_d = sticky_q || (err != ERR_NONE);
  end

  always_comb begin
    if (data_byte_i == 8'h26)                kind = K_AMP;
    else if (data_byte_i == 8'h3C)           kind = K_LT;
    else if (data_byte_i == 8'h3E)           kind = K_GT;
    else if (mode_i && data_byte_i == 8'h22) kind = K_QUOT;
    else if (mode_i && data_byte_i == 8'h09) kind = K_TAB;
    else if (mode_i && data_byte_i == 8'h0A) kind = K_LF;
    else if (mode_i && data_byte_i == 8'h0D) kind = K_CR;
    else                                     kind = K_PLAIN;
  end

  always_comb begin
    desc_o.data_byte = data_byte_i;
    desc_o.kind      = kind;
    desc_o.eos       = eos_i;
    desc_o.report    = (!sticky_q && err != ERR_NONE) ? err : ERR_NONE;
    desc_o.err_seen  = sticky_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      rem_q    <= '0;
      len_q    <= '0;
      sticky_q <= 1'b0;
    end else if (push_o) begin
      if (eos_i) begin
        acc_q    <= '0;
        rem_q    <= '0;
        len_q    <= '0;
        sticky_q <= 1'b0;
      end else begin
        acc_q    <= acc_d;
        rem_q    <= rem_d;
        len_q    <= len_d;
        sticky_q <= sticky_d;
      end
    end
  end

endmodule

// ===== rtl/xtu_fifo.sv =====
// ----------------------------------------------------------------------------
// xtu_fifo
// Short descriptor queue decoupling the classifier from the byte emitter.
// ----------------------------------------------------------------------------
module xtu_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xtu_pkg::desc_t push_data_i,
  input  logic           pop_i,
  output xtu_pkg::desc_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import xtu_pkg::*;

  desc_t            slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/xtu_back.sv =====
// ----------------------------------------------------------------------------
// xtu_back
// Expand each descriptor into its output bytes through a registered output.
// ----------------------------------------------------------------------------
module xtu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  xtu_pkg::desc_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_of_run_o,
  output logic           string_end_o,
  output logic [2:0]     error_code_o,
  output logic           error_seen_o
);
  import xtu_pkg::*;

  logic [2:0] idx_q;
  logic       valid_q;
  logic       load;
  logic       last;
  logic [7:0] byte_q;
  logic       lor_q, se_q, es_q;
  logic [2:0] ec_q;

  assign load  = !empty_i && (!valid_q || ready_i);
  assign last  = (idx_q == ent_len(head_i.kind) - 3'd1);
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load)         valid_q <= 1'b1;
      else if (ready_i) valid_q <= 1'b0;
      if (load) idx_q <= last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= ent_byte(head_i.kind, idx_q, head_i.data_byte);
      lor_q  <= last;
      se_q   <= last && head_i.eos;
      ec_q   <= last ? head_i.report : ERR_NONE;
      es_q   <= head_i.err_seen;
    end
  end

  assign valid_o       = valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = lor_q;
  assign string_end_o  = se_q;
  assign error_code_o  = ec_q;
  assign error_seen_o  = es_q;

endmodule

// ===== rtl/xml_text_utf8_check_escape.sv =====
// ----------------------------------------------------------------------------
// xml_text_utf8_check_escape
// UTF-8 validating XML escaper: one string byte in, one to six bytes out.
// ----------------------------------------------------------------------------
// Each input transaction carries one byte of a UTF-8 string, the escape mode
// in tuser (0 element text, 1 attribute value) and tlast on the final byte.
// The front decodes UTF-8 and checks the code point against the XML 1.0
// character set as the byte arrives, then queues a descriptor; the back turns
// each descriptor into the byte itself or its entity (&amp; &lt; &gt; always,
// &quot; and the numeric forms of tab, line feed and carriage return in
// attribute mode). Plain text streams at one byte per clock while the output
// is not stalled; an escaped byte leaves as its whole entity (4 to 6 bytes),
// one byte at a time through the single-byte output register. A four-entry
// queue lets the input keep flowing across short bursts of entities and
// across output stalls. The first error of a string appears once as a
// nonzero error code on the last output byte of the offending input;
// error_seen stays high from there to the string's end, and downstream should
// drop that whole string. Each byte passes through a queue slot and then the
// output register on its way out.
// ----------------------------------------------------------------------------
module xml_text_utf8_check_escape (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] data_byte
  input  logic [0:0] s_tuser_i,   // [0] mode
  input  logic       s_tlast_i,   // end_of_string
  // output stream
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // [7:0] out_byte
  output logic [4:0] m_tuser_o,   // [0] last_of_run, [3:1] error_code, [4] error_seen
  output logic       m_tlast_o    // string_end
);
  import xtu_pkg::*;

  desc_t      push_desc;
  desc_t      head_desc;
  logic       push, pop, q_empty, q_full;
  logic       lor, se, es;
  logic [2:0] ec;

  // Classify and decode on the accepting edge; queue the result
  xtu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_tvalid_i),
    .ready_o     (s_tready_o),
    .data_byte_i (s_tdata_i),
    .mode_i      (s_tuser_i[0]),
    .eos_i       (s_tlast_i),
    .full_i      (q_full),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  // Hold descriptors until the back has room
  xtu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .head_o      (head_desc),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // Emit one output byte per cycle while the output is not stalled; advance through entities
  xtu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_desc),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .valid_o       (m_tvalid_o),
    .ready_i       (m_tready_i),
    .out_byte_o    (m_tdata_o),
    .last_of_run_o (lor),
    .string_end_o  (se),
    .error_code_o  (ec),
    .error_seen_o  (es)
  );

  assign m_tuser_o = {es, ec, lor};
  assign m_tlast_o = se;

endmodule

// ===== rtl/xtu_checker.sv =====
// ----------------------------------------------------------------------------
// xtu_checker
// Port-level checks of the output stream, bound to the top level.
// ----------------------------------------------------------------------------
module xtu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_tvalid_o,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_o,
  input logic [4:0] m_tuser_o,
  input logic       m_tlast_o
);
  import xtu_pkg::*;

  // A stalled output transaction holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=>
      m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o) && $stable(m_tlast_o))
    else $error("output changed while stalled");

  // String end only on the last byte of a run
  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tlast_o |-> m_tuser_o[0])
    else $error("string end without last of run");

  // A reported error sits on the last byte of its run and sets error_seen
  a_err_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[3:1] != ERR_NONE |-> m_tuser_o[0] && m_tuser_o[4])
    else $error("error code misplaced");

  // Only defined error codes appear
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tuser_o[3:1] <= ERR_FORBIDDEN)
    else $error("undefined error code");

endmodule

bind xml_text_utf8_check_escape xtu_checker u_xtu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o),
  .m_tlast_o  (m_tlast_o)
);

// ===== bench/xml_text_utf8_check_escape_tb.sv =====
// ----------------------------------------------------------------------------
// xml_text_utf8_check_escape_tb
// Self-checking bench for the UTF-8 validating XML escaper.
// ----------------------------------------------------------------------------
// Feeds strings byte by byte into the input stream and rebuilds every output
// byte in a predictor that decodes UTF-8, applies the XML 1.0 character rules
// and expands entities. A checker compares every output transaction with
// the oldest predicted byte. The run covers directed entity and fault strings,
// random strings that are mostly well formed with random content, and a
// burst with no idle cycles on either side.
// ----------------------------------------------------------------------------
module xml_text_utf8_check_escape_tb;
  import xtu_pkg::*;

  localparam int TIMEOUT_CYCLES = 300000;
  localparam int IDLE_PCT       = 31;
  // Bytes that may turn into an entity, packed eight bits apiece
  localparam logic [55:0] ESC_CHARS = 56'h26_3C_3E_22_09_0A_0D;

  // One predicted output transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_end;
    logic [2:0] error_code;
    logic       error_seen;
  } out_beat_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       s_tvalid_i = 1'b0;
  logic       s_tready_o;
  logic [7:0] s_tdata_i  = 8'h00;  // [7:0] data_byte
  logic [0:0] s_tuser_i  = 1'b0;   // [0] mode
  logic       s_tlast_i  = 1'b0;   // end_of_string
  logic       m_tvalid_o;
  logic       m_tready_i = 1'b0;
  logic [7:0] m_tdata_o;           // [7:0] out_byte
  logic [4:0] m_tuser_o;           // [0] last_of_run, [3:1] error_code, [4] error_seen
  logic       m_tlast_o;           // string_end

  // Predictor state: decoder registers of the block
  logic [20:0] code_acc    = '0;
  logic [1:0]  cont_left   = '0;
  logic [1:0]  seq_kind    = '0;   // 1..3 for two- to four-byte sequences
  logic        err_latched = 1'b0;

  out_beat_t  expected_beats[$];
  out_beat_t  want_beat;
  logic [7:0] str_buf[$];
  bit         idle_en    = 1'b1;
  int         mismatches = 0;
  int         items_sent = 0;

  xml_text_utf8_check_escape DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the output stream hangs
  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit legal_xml_char(input logic [20:0] cp);
    return (cp == 21'h09) || (cp == 21'h0A) || (cp == 21'h0D) ||
           (cp >= 21'h20 && cp <= 21'hD7FF) ||
           (cp >= 21'hE000 && cp <= 21'hFFFD) ||
           (cp >= 21'h10000 && cp <= 21'h10FFFF);
  endfunction

  // Decode one accepted byte, update the decoder state and queue the bytes
  // it expands to
  function automatic void escape_and_check(input logic [7:0] b, input logic attr,
                                           input logic eos);
    logic [2:0] fault;
    logic [2:0] report;
    logic [20:0] cp;
    string ent;
    int n;
    out_beat_t beat;
    fault = ERR_NONE;
    ent = "";
    if (cont_left == 2'd0) begin
      if (b < 8'h80) begin
        if (!legal_xml_char({13'd0, b})) fault = ERR_FORBIDDEN;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        code_acc = {16'd0, b[4:0]}; cont_left = 2'd1; seq_kind = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        code_acc = {17'd0, b[3:0]}; cont_left = 2'd2; seq_kind = 2'd2;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        code_acc = {18'd0, b[2:0]}; cont_left = 2'd3; seq_kind = 2'd3;
      end else begin
        fault = ERR_BAD_LEAD;
      end
    end else if (b[7:6] != 2'b10) begin
      // Drop the pending sequence; this byte does not start a new one
      fault = ERR_BAD_CONT;
      code_acc = '0; cont_left = 2'd0; seq_kind = 2'd0;
    end else begin
      cp = {code_acc[14:0], b[5:0]};
      code_acc = cp;
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if ((seq_kind == 2'd2 && cp < 21'h800) || (seq_kind == 2'd3 && cp < 21'h10000) ||
            cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF))
          fault = ERR_NONCANON;
        else if (!legal_xml_char(cp))
          fault = ERR_FORBIDDEN;
        seq_kind = 2'd0;
      end
    end
    if (eos && cont_left != 2'd0 && fault == ERR_NONE) fault = ERR_TRUNC;

    // Report only the first fault of the string
    report = (!err_latched && fault != ERR_NONE) ? fault : ERR_NONE;
    if (fault != ERR_NONE) err_latched = 1'b1;

    case (b)
      8'h26: ent = "&amp;";
      8'h3C: ent = "&lt;";
      8'h3E: ent = "&gt;";
      8'h22: if (attr) ent = "&quot;";
      8'h09: if (attr) ent = "&#x9;";
      8'h0A: if (attr) ent = "&#xA;";
      8'h0D: if (attr) ent = "&#xD;";
      default: ;
    endcase
    n = (ent.len() == 0) ? 1 : ent.len();
    for (int k = 0; k < n; k++) begin
      beat.out_byte    = (ent.len() == 0) ? b : ent[k];
      beat.last_of_run = (k == n - 1);
      beat.string_end  = (k == n - 1) && eos;
      beat.error_code  = (k == n - 1) ? report : ERR_NONE;
      beat.error_seen  = err_latched;
      expected_beats.insert(expected_beats.size(), beat);
    end

    if (eos) begin
      code_acc = '0; cont_left = 2'd0; seq_kind = 2'd0; err_latched = 1'b0;
    end
  endfunction

  // Drive one input transaction, idling at random first, and predict it once
  // it is accepted
  task automatic send_byte(input logic [7:0] b, input logic attr, input logic eos);
    while (idle_en && $urandom_range(99, 0) < IDLE_PCT) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tuser_i  <= attr;
    s_tlast_i  <= eos;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    escape_and_check(b, attr, eos);
    items_sent++;
  endtask

  // Append one byte to the string under construction
  function automatic void add_byte(input logic [7:0] b);
    str_buf.insert(str_buf.size(), b);
  endfunction

  // Append the top n bytes of word to the string under construction
  function automatic void queue_bytes(input logic [31:0] word, input int n);
    for (int i = 0; i < n; i++) add_byte(word[31 - 8 * i -: 8]);
  endfunction

  // Encode cp in len bytes; a len above the natural one gives an overlong form
  function automatic void append_utf8(input logic [20:0] cp, input int len);
    case (len)
      1: add_byte(cp[7:0]);
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic int utf8_len(input logic [20:0] cp);
    return (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
  endfunction

  // Pick one character from a weighted mix of classes and append its bytes
  function automatic void append_random_char();
    logic [20:0] cp;
    int len;
    case ($urandom_range(15, 0))
      0, 1: begin
        cp = {13'd0, ESC_CHARS[8 * $urandom_range(6, 0) +: 8]};
        len = 1;
      end
      2, 3, 4: begin
        cp = 21'($urandom_range(8'h7E, 8'h20));
        len = 1;
      end
      5: begin
        // Control characters, mostly forbidden
        cp = 21'($urandom_range(32, 0));
        if (cp == 21'd32) cp = 21'h7F;
        len = 1;
      end
      6, 7: begin
        cp = 21'($urandom_range(21'h7FF, 21'h80));
        len = 2;
      end
      8, 9: begin
        cp = 21'($urandom_range(21'hFFFF, 21'h800));
        len = 3;
      end
      10: begin
        // Edges of the legal ranges, surrogates and noncharacters
        case ($urandom_range(13, 0))
          0:       cp = 21'hD7FF;
          1:       cp = 21'hD800;
          2:       cp = 21'hDFFF;
          3:       cp = 21'hE000;
          4:       cp = 21'hFFFD;
          5:       cp = 21'hFFFE;
          6:       cp = 21'hFFFF;
          7:       cp = 21'h10000;
          8:       cp = 21'h10FFFF;
          9:       cp = 21'h7F;
          10:      cp = 21'h80;
          11:      cp = 21'h7FF;
          12:      cp = 21'h800;
          default: cp = 21'h20;
        endcase
        len = utf8_len(cp);
      end
      11, 12: begin
        cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
        len = 4;
      end
      13: begin
        // Overlong form: one byte longer than needed
        cp = 21'($urandom_range(21'hFFFF, 21'h0));
        len = utf8_len(cp) + 1;
        if (len > 4) len = 4;
      end
      14: begin
        cp = 21'($urandom_range(21'h1FFFFF, 21'h110000));
        len = 4;
      end
      default: begin
        cp = 21'($urandom_range(255, 0));
        add_byte(cp[7:0]);
        len = 0;
      end
    endcase
    if (len != 0) append_utf8(cp, len);
  endfunction

  // Send the built string with tlast on its final byte; optionally flip the
  // mode on a few bytes
  task automatic send_string(input logic attr, input bit mix_mode);
    logic m;
    for (int i = 0; i < str_buf.size(); i++) begin
      m = attr;
      if (mix_mode && $urandom_range(9, 0) == 0) m = ~attr;
      send_byte(str_buf[i], m, i == str_buf.size() - 1);
    end
    str_buf.delete();
  endtask

  // Build one random string, mostly well formed, sometimes broken
  task automatic send_random_string();
    int nchar;
    int r;
    nchar = $urandom_range(6, 1);
    for (int i = 0; i < nchar; i++) append_random_char();
    r = $urandom_range(99, 0);
    if (r < 8) begin
      str_buf[$urandom_range(str_buf.size() - 1, 0)] = 8'($urandom_range(255, 0));
    end else if (r < 14 && str_buf.size() > 1) begin
      str_buf.delete(str_buf.size() - 1);
    end else if (r < 18) begin
      add_byte(8'($urandom_range(8'hBF, 8'h80)));
    end
    send_string(1'($urandom_range(1, 0)), 1'b1);
  endtask

  // Every entity byte in text mode, then the attribute-only ones
  task automatic test_escape_entities();
    queue_bytes(32'h263C3E22, 4);
    queue_bytes(32'h090A0D7F, 4);
    send_string(1'b0, 1'b0);
    queue_bytes(32'h22090A0D, 4);
    send_string(1'b1, 1'b0);
  endtask

  // One string per reported fault kind, two for the noncanonical one; the first also hides a second fault
  task automatic test_utf8_faults();
    queue_bytes(32'h00FF0000, 2);  // forbidden, then an unreported bad lead
    send_string(1'b0, 1'b0);
    queue_bytes(32'hC3410000, 2);  // bad continuation
    send_string(1'b0, 1'b0);
    queue_bytes(32'hE0808000, 3);  // overlong three-byte form
    send_string(1'b1, 1'b0);
    queue_bytes(32'hF4908080, 4);  // above the last code point
    send_string(1'b0, 1'b0);
    queue_bytes(32'hE2000000, 1);  // lead byte that ends the string
    send_string(1'b1, 1'b0);
  endtask

  task automatic test_random_strings(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_random_string();
  endtask

  // Hold both sides busy: no idle input cycles and no output stalls
  task automatic test_no_idle_burst(input int count);
    idle_en = 1'b0;
    test_random_strings(count);
    idle_en = 1'b1;
  endtask

  // Stall the output at random while idling is on
  always @(posedge clk_i) begin
    m_tready_i <= !idle_en || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  // Compare every output transaction with the oldest predicted byte
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected output byte %02h", m_tdata_o);
        mismatches++;
      end else begin
        want_beat = expected_beats.pop_front();
        if (m_tdata_o !== want_beat.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want_beat.out_byte, m_tdata_o);
          mismatches++;
        end
        if (m_tuser_o[0] !== want_beat.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want_beat.last_of_run,
                 m_tuser_o[0]);
          mismatches++;
        end
        if (m_tlast_o !== want_beat.string_end) begin
          $error("string_end: expected %0d, got %0d", want_beat.string_end, m_tlast_o);
          mismatches++;
        end
        if (m_tuser_o[3:1] !== want_beat.error_code) begin
          $error("error_code: expected %0d, got %0d", want_beat.error_code,
                 m_tuser_o[3:1]);
          mismatches++;
        end
        if (m_tuser_o[4] !== want_beat.error_seen) begin
          $error("error_seen: expected %0d, got %0d", want_beat.error_seen,
                 m_tuser_o[4]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    // Hold reset, then release it for good
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_escape_entities();
    test_utf8_faults();
    test_random_strings(256);
    test_no_idle_burst(80);
    s_tvalid_i <= 1'b0;

    // Drain the output, then give the pipeline time to show stray bytes
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/xtu_pkg.sv
rtl/xtu_front.sv
rtl/xtu_fifo.sv
rtl/xtu_back.sv
rtl/xml_text_utf8_check_escape.sv
rtl/xtu_checker.sv
bench/xml_text_utf8_check_escape_tb.sv
